[sv/mps_pkg.sv]
// Shared types, codes and constants of the motor pulse sequencer.
package mps_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned REQ_W    = 8;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PROD_W   = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  // Reciprocal of 25 for a 22-bit dividend: floor(x / 100) is
  // ((x >> 2) * RECIP_25) >> RECIP_SHIFT, exact over the whole range.
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP_25 = 23'd5368710;

  localparam logic [DUTY_W-1:0] DUTY_LIMIT = 7'd100;
  localparam logic [PROD_W-1:0] DUTY_ROUND = 24'd50;

  localparam logic [DUTY_W-1:0]   RST_DUTY_CAP = 7'd10;
  localparam logic [TICKS_W-1:0]  RST_PAUSE    = 16'd100;
  localparam logic [TICKS_W-1:0]  RST_PULSE    = 16'd1000;
  localparam logic [PERIOD_W-1:0] RST_PERIOD   = 17'd400;
  localparam logic [DUTY_W-1:0]   RST_SELECTED = 7'd10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_SELECT = 3'd1,
    FUNC_FWD    = 3'd2,
    FUNC_REV    = 3'd3,
    FUNC_STOP   = 3'd4
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_CAP = 3'd0,
    CFG_PAUSE    = 3'd1,
    CFG_PULSE    = 3'd2,
    CFG_PERIOD   = 3'd3,
    CFG_POLARITY = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_WAIT    = 2'd1,
    PH_FWD     = 2'd2,
    PH_REV     = 2'd3
  } phase_t;

  // Item state handed from the sequencing stage to the compare stage.
  typedef struct packed {
    phase_t              phase;
    logic [DUTY_W-1:0]   driven_duty;
    logic [DUTY_W-1:0]   chosen_duty;
    logic                dir_a;
    logic                dir_b;
    logic                enable_n;
    logic                auto_stopped;
    logic                drive_start;
    logic                bridge_off;
    logic [PROD_W-1:0]   product;
  } stage_t;

endpackage

[sv/motor_pulse_sequencer.sv]
// Top level of the motor pulse sequencer: timed H-bridge pulses on an item stream.
//
//  Channel   Direction  Handshake          Contents
//  s_axis    in         tvalid/tready      func, duty_request
//  m_axis    out        tvalid/tready      run_state .. auto_stopped
//  cfg       in         cfg_we             cfg_index, cfg_data
//
// Each item passes two register stages: sequencing, then the compare stage with its
// reciprocal multiply. One item is taken per cycle while no held result stalls the stages.
// Synchronous reset restores the register defaults and a stopped bridge.
// A held result stalls the stages behind it; bubbles are filled as they arrive.
module motor_pulse_sequencer
  import mps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [2:0] func, [10:3] duty_request
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] run_state, [8:2] driven duty, [15:9] chosen_duty, [16] dir_a,
  // [17] dir_b, [18] enable_n, [35:19] pwm_compare, [36] auto_stopped
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic   stage_valid;
  stage_t stage;
  logic   advance;
  logic   take;

  assign s_axis_tready = !stage_valid || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  mps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .func         (s_axis_tdata[FUNC_W-1:0]),
    .duty_request (s_axis_tdata[FUNC_W +: REQ_W]),
    .advance      (advance),
    .stage_valid  (stage_valid),
    .stage        (stage)
  );

  mps_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .advance     (advance),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata)
  );

endmodule

[sv/mps_ctrl.sv]
// Sequencing stage: configuration, phase and deadline tracking, compare product.
module mps_ctrl
  import mps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  take,
  input  logic [FUNC_W-1:0]     func,
  input  logic [REQ_W-1:0]      duty_request,
  input  logic                  advance,
  output logic                  stage_valid,
  output stage_t                stage
);

  logic [DUTY_W-1:0]   cfg_duty_cap;
  logic [TICKS_W-1:0]  cfg_pause;
  logic [TICKS_W-1:0]  cfg_pulse;
  logic [PERIOD_W-1:0] cfg_period;
  logic                cfg_polarity;

  phase_t              phase, phase_next;
  logic [DUTY_W-1:0]   selected, selected_next;
  logic                pending_fwd, pending_fwd_next;
  logic [TIME_W-1:0]   tick_time, tick_time_next;
  logic [TIME_W-1:0]   start_limit, start_limit_next;
  logic [TIME_W-1:0]   stop_limit, stop_limit_next;
  logic [DUTY_W-1:0]   driven, driven_next;
  logic                dir_a, dir_a_next;
  logic                dir_b, dir_b_next;
  logic                enable_n, enable_n_next;

  logic [DUTY_W-1:0]   duty_top;
  logic [DUTY_W-1:0]   req_clamped;
  logic [DUTY_W-1:0]   drive_duty;
  logic [TIME_W-1:0]   tick_inc;
  logic [TIME_W-1:0]   start_diff;
  logic [TIME_W-1:0]   stop_diff;
  logic                a_high;
  logic                ended, starting, stopping;
  logic [PROD_W-1:0]   product;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_duty_cap <= RST_DUTY_CAP;
      cfg_pause    <= RST_PAUSE;
      cfg_pulse    <= RST_PULSE;
      cfg_period   <= RST_PERIOD;
      cfg_polarity <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DUTY_CAP: cfg_duty_cap <= cfg_data[DUTY_W-1:0];
        CFG_PAUSE:    cfg_pause    <= cfg_data[TICKS_W-1:0];
        CFG_PULSE:    cfg_pulse    <= cfg_data[TICKS_W-1:0];
        CFG_PERIOD:   cfg_period   <= cfg_data[PERIOD_W-1:0];
        CFG_POLARITY: cfg_polarity <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp limit is the smaller of the register and one hundred.
  assign duty_top    = (cfg_duty_cap < DUTY_LIMIT) ? cfg_duty_cap : DUTY_LIMIT;
  assign req_clamped = (duty_request <= {1'b0, duty_top}) ? duty_request[DUTY_W-1:0]
                                                         : duty_top;
  assign drive_duty  = (selected <= duty_top) ? selected : duty_top;
  assign tick_inc    = tick_time + 32'd1;
  // Wrap-safe deadline test: reached when the difference is not negative.
  assign start_diff  = tick_inc - start_limit;
  assign stop_diff   = tick_inc - stop_limit;
  assign a_high      = pending_fwd ? cfg_polarity : ~cfg_polarity;
  assign product     = PROD_W'(cfg_period) * PROD_W'(drive_duty) + DUTY_ROUND;

  // Next state.
  always_comb begin
    phase_next       = phase;
    selected_next    = selected;
    pending_fwd_next = pending_fwd;
    tick_time_next   = tick_time;
    start_limit_next = start_limit;
    stop_limit_next  = stop_limit;
    driven_next      = driven;
    dir_a_next       = dir_a;
    dir_b_next       = dir_b;
    enable_n_next    = enable_n;
    starting         = 1'b0;
    stopping         = 1'b0;
    ended            = 1'b0;
    case (func) inside
      FUNC_TICK: begin
        tick_time_next = tick_inc;
        if (phase == PH_WAIT && !start_diff[TIME_W-1]) begin
          starting        = 1'b1;
          dir_a_next      = a_high;
          dir_b_next      = ~a_high;
          enable_n_next   = 1'b0;
          driven_next     = drive_duty;
          phase_next      = pending_fwd ? PH_FWD : PH_REV;
          stop_limit_next = tick_inc + TIME_W'(cfg_pulse);
        end else if ((phase == PH_FWD || phase == PH_REV) && !stop_diff[TIME_W-1]) begin
          stopping   = 1'b1;
          ended      = 1'b1;
          phase_next = PH_STOPPED;
        end
      end
      FUNC_SELECT: selected_next = req_clamped;
      FUNC_FWD, FUNC_REV: begin
        stopping         = 1'b1;
        pending_fwd_next = (func == FUNC_FWD);
        start_limit_next = tick_time + TIME_W'(cfg_pause);
        phase_next       = PH_WAIT;
      end
      FUNC_STOP: begin
        stopping   = 1'b1;
        phase_next = PH_STOPPED;
      end
      default: ;
    endcase
    if (stopping) begin
      driven_next   = '0;
      dir_a_next    = 1'b0;
      dir_b_next    = 1'b0;
      enable_n_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STOPPED;
      selected    <= RST_SELECTED;
      pending_fwd <= 1'b1;
      tick_time   <= '0;
      start_limit <= '0;
      stop_limit  <= '0;
      driven      <= '0;
      dir_a       <= 1'b0;
      dir_b       <= 1'b0;
      enable_n    <= 1'b1;
    end else if (take) begin
      phase       <= phase_next;
      selected    <= selected_next;
      pending_fwd <= pending_fwd_next;
      tick_time   <= tick_time_next;
      start_limit <= start_limit_next;
      stop_limit  <= stop_limit_next;
      driven      <= driven_next;
      dir_a       <= dir_a_next;
      dir_b       <= dir_b_next;
      enable_n    <= enable_n_next;
    end
  end

  // Stage register towards the compare stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage.phase        <= phase_next;
      stage.driven_duty  <= driven_next;
      stage.chosen_duty  <= selected_next;
      stage.dir_a        <= dir_a_next;
      stage.dir_b        <= dir_b_next;
      stage.enable_n     <= enable_n_next;
      stage.auto_stopped <= ended;
      stage.drive_start  <= starting;
      stage.bridge_off   <= stopping;
      stage.product      <= product;
    end
  end

endmodule

[sv/mps_scale.sv]
// Compare stage: divides the rounded product by one hundred and holds the result item.
module mps_scale
  import mps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  stage_valid,
  input  stage_t                stage,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int unsigned DIV_IN_W = PROD_W - 2;
  localparam int unsigned MUL_W    = DIV_IN_W + RECIP_W;

  logic [PERIOD_W-1:0] compare_value, compare_next;
  logic [MUL_W-1:0]    recip_prod;
  logic [PERIOD_W-1:0] quotient;

  assign advance    = stage_valid && (!out_valid || out_ready);
  assign recip_prod = MUL_W'(stage.product[PROD_W-1:2]) * MUL_W'(RECIP_25);
  assign quotient   = recip_prod[RECIP_SHIFT +: PERIOD_W];

  always_comb begin
    compare_next = compare_value;
    if (stage.drive_start) begin
      compare_next = quotient;
    end else if (stage.bridge_off) begin
      compare_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_value <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        compare_value <= compare_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {3'b000, stage.auto_stopped, compare_next, stage.enable_n, stage.dir_b,
                   stage.dir_a, stage.chosen_duty, stage.driven_duty, stage.phase};
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the motor pulse sequencer, scored item by item against a predictor.
module testbench;
  import mps_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 90;
  localparam int unsigned SPAN_CAP     = 30;

  // Function codes that the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

  typedef struct packed {
    logic [2:0]          pad;
    logic                auto_stopped;
    logic [PERIOD_W-1:0] pwm_compare;
    logic                enable_n;
    logic                dir_b;
    logic                dir_a;
    logic [DUTY_W-1:0]   chosen_duty;
    logic [DUTY_W-1:0]   driven_duty;
    phase_t              run_state;
  } bridge_report_t;

  typedef struct packed {
    logic [FUNC_W-1:0] code;
    logic [REQ_W-1:0]  duty;
  } motor_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  motor_pulse_sequencer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Register copies.
  logic [DUTY_W-1:0]   lim_duty_cap;
  logic [TICKS_W-1:0]  lim_pause;
  logic [TICKS_W-1:0]  lim_pulse;
  logic [PERIOD_W-1:0] lim_period;
  logic                lim_fwd_pol;

  // Sequencer state as predicted.
  phase_t              seq_phase;
  logic [DUTY_W-1:0]   sel_pct;
  logic                fwd_pending;
  logic [TIME_W-1:0]   tick_count;
  logic [TIME_W-1:0]   start_deadline;
  logic [TIME_W-1:0]   stop_deadline;
  logic [DUTY_W-1:0]   drive_pct;
  logic [PERIOD_W-1:0] cmp_level;
  logic                pin_a;
  logic                pin_b;
  logic                pin_en_n;

  motor_cmd_t     pending_cmds[$];
  bridge_report_t expected_reports[$];
  motor_cmd_t     offered_cmd;
  bridge_report_t seen_report;
  bridge_report_t want_report;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned reports_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  function automatic logic [DUTY_W-1:0] clamp_percent(input logic [REQ_W-1:0] want);
    logic [DUTY_W-1:0] ceiling;
    ceiling = (lim_duty_cap < DUTY_LIMIT) ? lim_duty_cap : DUTY_LIMIT;
    return (want <= {1'b0, ceiling}) ? want[DUTY_W-1:0] : ceiling;
  endfunction

  // A deadline counts as reached while the signed distance to it is not negative.
  function automatic logic deadline_reached(input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] diff;
    diff = tick_count - deadline;
    return !diff[TIME_W-1];
  endfunction

  function automatic void park_bridge();
    drive_pct = '0;
    cmp_level = '0;
    pin_a = 1'b0;
    pin_b = 1'b0;
    pin_en_n = 1'b1;
  endfunction

  function automatic void reset_predictor();
    lim_duty_cap = RST_DUTY_CAP;
    lim_pause = RST_PAUSE;
    lim_pulse = RST_PULSE;
    lim_period = RST_PERIOD;
    lim_fwd_pol = 1'b1;
    seq_phase = PH_STOPPED;
    sel_pct = RST_SELECTED;
    fwd_pending = 1'b1;
    tick_count = '0;
    start_deadline = '0;
    stop_deadline = '0;
    park_bridge();
  endfunction

  function automatic bridge_report_t advance_sequencer(input motor_cmd_t cmd);
    bridge_report_t rep;
    logic [DUTY_W-1:0] duty;
    logic a_high;
    logic ended;
    int unsigned scaled;
    ended = 1'b0;
    case (cmd.code) inside
      FUNC_TICK: begin
        tick_count = tick_count + 32'd1;
        if (seq_phase == PH_WAIT && deadline_reached(start_deadline)) begin
          a_high = fwd_pending ? lim_fwd_pol : !lim_fwd_pol;
          // The duty is clamped again here, so a lowered maximum takes effect.
          duty = clamp_percent({1'b0, sel_pct});
          scaled = 32'(lim_period) * 32'(duty);
          scaled = (scaled + 32'(DUTY_ROUND)) / 32'(DUTY_LIMIT);
          cmp_level = scaled[PERIOD_W-1:0];
          pin_a = a_high;
          pin_b = !a_high;
          pin_en_n = 1'b0;
          drive_pct = duty;
          seq_phase = fwd_pending ? PH_FWD : PH_REV;
          stop_deadline = tick_count + 32'(lim_pulse);
        end else if ((seq_phase == PH_FWD || seq_phase == PH_REV)
                     && deadline_reached(stop_deadline)) begin
          park_bridge();
          seq_phase = PH_STOPPED;
          ended = 1'b1;
        end
      end
      FUNC_SELECT: sel_pct = clamp_percent(cmd.duty);
      FUNC_FWD, FUNC_REV: begin
        park_bridge();
        fwd_pending = (cmd.code == FUNC_FWD);
        start_deadline = tick_count + 32'(lim_pause);
        seq_phase = PH_WAIT;
      end
      FUNC_STOP: begin
        park_bridge();
        seq_phase = PH_STOPPED;
      end
      default: ;
    endcase
    rep = '0;
    rep.run_state = seq_phase;
    rep.driven_duty = drive_pct;
    rep.chosen_duty = sel_pct;
    rep.dir_a = pin_a;
    rep.dir_b = pin_b;
    rep.enable_n = pin_en_n;
    rep.pwm_compare = cmp_level;
    rep.auto_stopped = ended;
    return rep;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Driver: holds an item until it is taken, then offers the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_reports.push_back(advance_sequencer(offered_cmd));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
          offered_cmd = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {{(IN_DATA_W - FUNC_W - REQ_W){1'b0}}, offered_cmd.duty,
                           offered_cmd.code};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: scores each result and now and then holds off for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_report = m_axis_tdata;
        if (expected_reports.size() == 0) begin
          $display("%0t: result with no item pending, expected none, got %h", $time,
                   m_axis_tdata);
          mismatches++;
        end else begin
          want_report = expected_reports.pop_front();
          check_field("run_state", 32'(want_report.run_state), 32'(seen_report.run_state));
          check_field("driven_duty", 32'(want_report.driven_duty),
                      32'(seen_report.driven_duty));
          check_field("chosen_duty", 32'(want_report.chosen_duty),
                      32'(seen_report.chosen_duty));
          check_field("dir_a", 32'(want_report.dir_a), 32'(seen_report.dir_a));
          check_field("dir_b", 32'(want_report.dir_b), 32'(seen_report.dir_b));
          check_field("enable_n", 32'(want_report.enable_n), 32'(seen_report.enable_n));
          check_field("pwm_compare", 32'(want_report.pwm_compare),
                      32'(seen_report.pwm_compare));
          check_field("auto_stopped", 32'(want_report.auto_stopped),
                      32'(seen_report.auto_stopped));
        end
        reports_taken++;
        if (reports_taken % 400 == 150)
          hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we || rst)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("motor_pulse_sequencer regression: fail");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [FUNC_W-1:0] code, input logic [REQ_W-1:0] duty);
    motor_cmd_t cmd;
    cmd.code = code;
    cmd.duty = duty;
    pending_cmds.push_back(cmd);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_DUTY_CAP: lim_duty_cap = value[DUTY_W-1:0];
      CFG_PAUSE:    lim_pause = value[TICKS_W-1:0];
      CFG_PULSE:    lim_pulse = value[TICKS_W-1:0];
      CFG_PERIOD:   lim_period = value[PERIOD_W-1:0];
      CFG_POLARITY: lim_fwd_pol = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits for the block to drain, then loads a new setting and pace.
  task automatic begin_phase(input int unsigned duty_cap, input int unsigned pause,
                             input int unsigned pulse, input int unsigned period,
                             input int unsigned polarity, input int unsigned gap,
                             input int unsigned stall);
    wait_idle();
    write_reg(CFG_DUTY_CAP, CFG_DATA_W'(duty_cap));
    write_reg(CFG_PAUSE, CFG_DATA_W'(pause));
    write_reg(CFG_PULSE, CFG_DATA_W'(pulse));
    write_reg(CFG_PERIOD, CFG_DATA_W'(period));
    write_reg(CFG_POLARITY, CFG_DATA_W'(polarity));
    send_gap_pct = gap;
    stall_pct = stall;
  endtask

  // Mostly whole pulse runs (request, then enough ticks to start and end the drive unless the
  // span is capped), some cut short, the rest single items of any kind.
  task automatic queue_random_items(input int unsigned count);
    int unsigned made;
    int unsigned span;
    int unsigned ticks;
    logic [FUNC_W-1:0] code;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99, 0) < 70) begin
        if ($urandom_range(2, 0) == 0) begin
          queue_cmd(FUNC_SELECT, $urandom_range(1, 0) ? REQ_W'($urandom_range(255, 0))
                                                      : REQ_W'($urandom_range(110, 0)));
          made++;
        end
        queue_cmd($urandom_range(1, 0) ? FUNC_FWD : FUNC_REV, REQ_W'($urandom_range(255, 0)));
        made++;
        span = 32'(lim_pause) + 32'(lim_pulse) + 3;
        if (span > SPAN_CAP)
          span = SPAN_CAP;
        ticks = ($urandom_range(3, 0) == 0) ? $urandom_range(span, 0) : span;
        repeat (ticks) queue_cmd(FUNC_TICK, REQ_W'($urandom_range(255, 0)));
        made += ticks;
        if ($urandom_range(4, 0) == 0) begin
          queue_cmd(FUNC_STOP, REQ_W'($urandom_range(255, 0)));
          made++;
        end
      end else begin
        code = FUNC_W'($urandom_range(7, 0));
        queue_cmd(code, REQ_W'($urandom_range(255, 0)));
        if (code <= FUNC_STOP)
          made++;
      end
    end
  endtask

  task automatic random_setting_phase(input int unsigned count);
    int unsigned pace;
    pace = $urandom_range(3, 0);
    begin_phase($urandom_range(127, 0), $urandom_range(6, 0), $urandom_range(6, 0),
                $urandom_range(131071, 0), $urandom_range(1, 0),
                (pace == 1) ? 55 : (pace == 3) ? 37 : 0,
                (pace == 2) ? 55 : (pace == 3) ? 37 : 0);
    queue_random_items(count);
  endtask

  initial begin
    reset_predictor();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: maximum above a hundred, zero pause and pulse, a period of 65536.
    begin_phase(127, 0, 0, 65536, 0, 0, 0);
    queue_cmd(FUNC_SELECT, 8'hFF);
    queue_cmd(FUNC_FWD, 8'h00);
    queue_cmd(FUNC_TICK, 8'h00);
    queue_cmd(FUNC_TICK, 8'h00);
    queue_cmd(FUNC_SELECT, 8'h00);
    queue_cmd(FUNC_REV, 8'hFF);
    queue_cmd(FUNC_TICK, 8'hFF);
    queue_cmd(FUNC_TICK, 8'h00);
    queue_cmd(FUNC_STOP, 8'h00);
    queue_cmd(FUNC_SPARE_A, 8'h00);
    queue_cmd(FUNC_SPARE_B, 8'hFF);
    queue_cmd(FUNC_SPARE_C, 8'h55);
    queue_cmd(FUNC_SELECT, 8'hAA);
    queue_cmd(FUNC_SELECT, 8'h55);
    queue_cmd(FUNC_FWD, 8'h00);
    queue_cmd(FUNC_STOP, 8'h00);
    queue_cmd(FUNC_REV, 8'h00);
    queue_cmd(FUNC_TICK, 8'h00);
    queue_cmd(FUNC_FWD, 8'h00);
    queue_cmd(FUNC_TICK, 8'h00);
    queue_cmd(FUNC_STOP, 8'h00);
    queue_cmd(FUNC_SELECT, 8'd100);
    queue_cmd(FUNC_REV, 8'h00);
    queue_cmd(FUNC_REV, 8'h00);
    queue_cmd(FUNC_TICK, 8'h00);
    queue_cmd(FUNC_TICK, 8'h00);

    // The maximum is lowered below the chosen duty, which drive start must clamp.
    begin_phase(50, 3, 5, 400, 1, 0, 0);
    queue_cmd(FUNC_FWD, 8'h00);
    repeat (4) queue_cmd(FUNC_TICK, 8'h00);
    queue_random_items(270);

    begin_phase(100, 0, 1, 1, 0, 55, 0);
    queue_random_items(270);
    // Zero period and a maximum of zero.
    begin_phase(0, 2, 0, 0, 1, 0, 55);
    queue_random_items(270);
    begin_phase(127, 65535, 2, 65536, 0, 37, 37);
    queue_random_items(100);
    begin_phase(37, 1, 65535, 131071, 1, 37, 37);
    queue_random_items(270);
    begin_phase(90, 4, 3, 1000, 0, 0, 0);
    queue_random_items(200);
    random_setting_phase(120);
    random_setting_phase(120);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("motor_pulse_sequencer regression: pass");
    end else begin
      $display("motor_pulse_sequencer regression: fail");
    end
    $finish;
  end

endmodule
